/* src/cascaded_biquad_filter_defines.svh */
// Assertion helpers for the filter top level.
`ifndef CASCADED_BIQUAD_FILTER_DEFINES_SVH
`define CASCADED_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define CBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/cbq_pkg.sv */
package cbq_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int MAX_SECTIONS = 2;
    localparam int DELAY_WIDTH  = 48;
    localparam int PROD_SHIFT   = 12;
    localparam int OUT_SHIFT    = COEF_WIDTH - 4 - PROD_SHIFT;
    localparam int THR_W        = 16;

    // datapath widths
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int RPROD_W = PROD_W - PROD_SHIFT;
    localparam int ACC_W   = ((RPROD_W > DELAY_WIDTH) ? RPROD_W : DELAY_WIDTH) + 2;
    localparam int YW      = ACC_W - OUT_SHIFT;

    localparam int SEC_IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SEC_CNT_W = $clog2(MAX_SECTIONS + 1);

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_t;

    // hand-off between neighboring sections
    typedef struct packed {
        logic                           go;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        logic                           clip;
    } link_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           clear_state;
    } cbq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           clipped;
    } cbq_out_t;

endpackage

/* src/cbq_section_cell.sv */
module cbq_section_cell
    import cbq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  coef_t            coef,
    input  logic [THR_W-1:0] flush_thr,
    input  logic             clear,
    input  link_t            upstream,
    output link_t            downstream
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MB0  = 3'd1;
    localparam logic [2:0] ST_MB1  = 3'd2;
    localparam logic [2:0] ST_MB2  = 3'd3;
    localparam logic [2:0] ST_MA1  = 3'd4;
    localparam logic [2:0] ST_MA2  = 3'd5;
    localparam logic [2:0] ST_SUB  = 3'd6;
    localparam logic [2:0] ST_WB   = 3'd7;

    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (PROD_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (OUT_SHIFT - 1);

    // saturate to the delay width, then zero small magnitudes
    function automatic logic signed [DELAY_WIDTH-1:0] settle(
        input logic signed [ACC_W-1:0] s,
        input logic [THR_W-1:0]        thr
    );
        logic signed [DELAY_WIDTH-1:0]  v;
        logic [DELAY_WIDTH-1:0]         mag;
        logic [ACC_W-DELAY_WIDTH:0]     top;
        top = s[ACC_W-1:DELAY_WIDTH-1];
        if (&top || ~|top)
            v = s[DELAY_WIDTH-1:0];
        else if (s[ACC_W-1])
            v = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
        else
            v = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
        mag = v[DELAY_WIDTH-1] ? $unsigned(-v) : $unsigned(v);
        if (mag <= {{(DELAY_WIDTH-THR_W){1'b0}}, thr})
            return '0;
        return v;
    endfunction

    logic [2:0]                      state_reg, state_next;
    logic                            done_reg;
    logic signed [SAMPLE_WIDTH-1:0]  x_reg, y_reg;
    logic                            clip_reg;
    logic signed [PROD_W-1:0]        p_reg, p_next;
    logic signed [ACC_W-1:0]         acc_reg, s1_reg, s2_reg;
    logic signed [DELAY_WIDTH-1:0]   d1_reg, d2_reg;

    logic signed [COEF_WIDTH-1:0]    mul_c;
    logic signed [SAMPLE_WIDTH-1:0]  mul_s;
    logic signed [PROD_W-1:0]        p_round;
    logic signed [RPROD_W-1:0]       rp;
    logic signed [ACC_W-1:0]         rp_ext;
    logic signed [ACC_W-1:0]         acc_round;
    logic signed [YW-1:0]            yw;
    logic [YW-SAMPLE_WIDTH:0]        y_top;
    logic                            y_hit;
    logic signed [SAMPLE_WIDTH-1:0]  y_sat;

    // one shared multiplier, operands picked by step
    always_comb
    begin
        case (state_reg)
            ST_MB1:  begin mul_c = coef.b1; mul_s = x_reg; end
            ST_MB2:  begin mul_c = coef.b2; mul_s = x_reg; end
            ST_MA1:  begin mul_c = coef.a1; mul_s = y_reg; end
            ST_MA2:  begin mul_c = coef.a2; mul_s = y_reg; end
            default: begin mul_c = coef.b0; mul_s = x_reg; end
        endcase
        p_next = mul_c * mul_s;
    end

    // round half up to delay units
    assign p_round = p_reg + PROD_HALF;
    assign rp      = p_round[PROD_W-1:PROD_SHIFT];
    assign rp_ext  = ACC_W'(rp);

    // section output: round to sample units and saturate
    assign acc_round = acc_reg + ACC_HALF;
    assign yw        = acc_round[ACC_W-1:OUT_SHIFT];
    assign y_top     = yw[YW-1:SAMPLE_WIDTH-1];
    assign y_hit     = !(&y_top || ~|y_top);
    always_comb
    begin
        if (!y_hit)
            y_sat = yw[SAMPLE_WIDTH-1:0];
        else if (yw[YW-1])
            y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = upstream.go ? ST_MB0 : ST_IDLE;
            ST_MB0:  state_next = ST_MB1;
            ST_MB1:  state_next = ST_MB2;
            ST_MB2:  state_next = ST_MA1;
            ST_MA1:  state_next = ST_MA2;
            ST_MA2:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_WB;
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            d1_reg    <= '0;
            d2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WB);
            if (clear)
            begin
                d1_reg <= '0;
                d2_reg <= '0;
            end
            else if (state_reg == ST_WB)
            begin
                d1_reg <= settle(s1_reg, flush_thr);
                d2_reg <= settle(s2_reg, flush_thr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (upstream.go)
                begin
                    x_reg    <= upstream.smp;
                    clip_reg <= upstream.clip;
                end
            end
            ST_MB1: acc_reg <= rp_ext + ACC_W'(d1_reg);
            ST_MB2:
            begin
                y_reg    <= y_sat;
                clip_reg <= clip_reg | y_hit;
                s1_reg   <= rp_ext + ACC_W'(d2_reg);
            end
            ST_MA1: s2_reg <= rp_ext;
            ST_MA2: s1_reg <= s1_reg - rp_ext;
            ST_SUB: s2_reg <= s2_reg - rp_ext;
            default: ;
        endcase
    end

    assign downstream = '{go: done_reg, smp: y_reg, clip: clip_reg};

endmodule

/* src/cascaded_biquad_filter.sv */
// An accepted request passes through the N active sections one after another.
// Requests are taken one at a time, sample_stall holds the next; each section
//   runs its five products through its own single multiplier, one per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset: delays zero, coefficients zero, section_count 2, flush_threshold 1.
`include "cascaded_biquad_filter_defines.svh"

module cascaded_biquad_filter
    import cbq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample requests
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  cbq_in_t               sample_req,
    // result requests
    output logic                  result_valid,
    input  logic                  result_stall,
    output cbq_out_t              result_req,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [COEF_WIDTH-1:0] cfg_data
);

    // register indexes
    localparam logic [2:0] REG_B0        = 3'd0;
    localparam logic [2:0] REG_B1        = 3'd1;
    localparam logic [2:0] REG_B2        = 3'd2;
    localparam logic [2:0] REG_A1        = 3'd3;
    localparam logic [2:0] REG_A2        = 3'd4;
    localparam logic [2:0] REG_SECTIONS  = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;

    localparam logic [1:0]       SECTIONS_RST  = 2'd2;
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(1);

    // configuration
    coef_t             coef_reg;
    logic [1:0]        section_count_reg;
    logic [THR_W-1:0]  flush_threshold_reg;

    // control
    logic              busy_reg, busy_next;
    logic              pend_reg, pend_next;
    logic              result_valid_reg, result_valid_next;
    cbq_out_t          result_reg;

    logic              accept;
    logic              clear;
    logic              out_free;
    logic              final_go;
    logic [SEC_CNT_W-1:0] n_eff;
    logic [SEC_IDX_W-1:0] last_idx;

    link_t             cell_in  [MAX_SECTIONS];
    link_t             cell_out [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] cell_go;
    link_t             fin;

    assign cfg_ready = 1'b1;

    // Register writes; indexes outside the list are dropped. Software is to write only
    // while the block is idle; the block itself does not guard against a running sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg            <= '0;
            section_count_reg   <= SECTIONS_RST;
            flush_threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_B0:        coef_reg.b0 <= cfg_data;
                REG_B1:        coef_reg.b1 <= cfg_data;
                REG_B2:        coef_reg.b2 <= cfg_data;
                REG_A1:        coef_reg.a1 <= cfg_data;
                REG_A2:        coef_reg.a2 <= cfg_data;
                REG_SECTIONS:  section_count_reg <= cfg_data[1:0];
                REG_THRESHOLD: flush_threshold_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Active section count: zero means one, above the chain length clips.
    always_comb
    begin
        if (section_count_reg == '0)
            n_eff = SEC_CNT_W'(1);
        else if (int'(section_count_reg) > MAX_SECTIONS)
            n_eff = SEC_CNT_W'(MAX_SECTIONS);
        else
            n_eff = SEC_CNT_W'(section_count_reg);
    end
    assign last_idx = SEC_IDX_W'(n_eff - SEC_CNT_W'(1));

    // one sample in flight; input waits while a section is working or its result waits for the output
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = busy_reg;
    // clear_state zeroes every section, active or not, before filtering
    assign clear        = accept && sample_req.clear_state;

    // Chain of sections: section 0 takes the new sample, each later active one starts
    // when its neighbor hands over its saturated output and running clip flag.
    for (genvar i = 0; i < MAX_SECTIONS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in[i] = '{go: accept, smp: sample_req.sample_in, clip: 1'b0};
        end
        else
        begin : g_link
            assign cell_in[i] = '{go:   cell_out[i-1].go && (SEC_CNT_W'(i) < n_eff),
                                  smp:  cell_out[i-1].smp,
                                  clip: cell_out[i-1].clip};
        end

        cbq_section_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .coef       (coef_reg),
            .flush_thr  (flush_threshold_reg),
            .clear      (clear),
            .upstream   (cell_in[i]),
            .downstream (cell_out[i])
        );

        assign cell_go[i] = cell_out[i].go;
    end

    // Last active section holds its output until the next sample starts, so a
    // full output register only needs a pending flag, not a copy.
    assign fin      = cell_out[last_idx];
    assign final_go = fin.go || pend_reg;
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        busy_next         = busy_reg;
        pend_next         = final_go && !out_free;
        result_valid_next = result_valid_reg;
        if (accept)
            busy_next = 1'b1;
        else if (final_go && out_free)
            busy_next = 1'b0;
        if (final_go && out_free)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (final_go && out_free)
            result_reg <= '{sample_out: fin.smp, clipped: fin.clip};
    end

    assign result_valid = result_valid_reg;
    assign result_req   = result_reg;

    // no section hands over while the block is idle
    `CBQ_ASSERT_IMPL(a_idle_quiet, clk, rst_n, !busy_reg, cell_go == '0)
    // sections work strictly one after another
    `CBQ_ASSERT_IMPL(a_one_handoff, clk, rst_n, busy_reg, $onehot0(cell_go))
    // a pending result only exists behind a full output register
    `CBQ_ASSERT_IMPL(a_pend_full, clk, rst_n, pend_reg, result_valid_reg)
    // an accepted request keeps the block busy
    `CBQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy_reg)

endmodule

/* tb/cascaded_biquad_filter_chk.sv */
`timescale 1ns / 1ps

package cbq_tb_pkg;

    // register map of the write port
    typedef enum logic [2:0] {
        REG_B0       = 3'd0,
        REG_B1       = 3'd1,
        REG_B2       = 3'd2,
        REG_A1       = 3'd3,
        REG_A2       = 3'd4,
        REG_SECTIONS = 3'd5,
        REG_FLUSH    = 3'd6,
        REG_UNUSED   = 3'd7
    } reg_idx_t;

endpackage

module cascaded_biquad_filter_chk
    import cbq_pkg::*;
    import cbq_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_stall,
    input  cbq_in_t               sample_req,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  cbq_out_t              result_req,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [COEF_WIDTH-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    // shadow of the register file
    coef_t             coefs;
    logic [1:0]        sec_cnt;
    logic [THR_W-1:0]  flush_lim;

    // per-section delay line
    logic signed [DELAY_WIDTH-1:0] z1 [MAX_SECTIONS];
    logic signed [DELAY_WIDTH-1:0] z2 [MAX_SECTIONS];

    cbq_out_t expected_results [$];
    cbq_out_t want;
    int       results_seen;

    // floor(v / 2^s + 1/2)
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint scaled_product(logic signed [COEF_WIDTH-1:0] c, longint x);
        return round_half_up(longint'(c) * x, PROD_SHIFT);
    endfunction

    // 48-bit saturation, then denormal-style flush
    function automatic logic signed [DELAY_WIDTH-1:0] settle_delay(longint v);
        longint hi;
        longint mag;
        hi = (longint'(1) <<< (DELAY_WIDTH - 1)) - 1;
        if (v > hi)
            v = hi;
        else if (v < -hi - 1)
            v = -hi - 1;
        mag = (v < 0) ? -v : v;
        if (mag <= longint'(flush_lim))
            return '0;
        return v[DELAY_WIDTH-1:0];
    endfunction

    function automatic cbq_out_t filter_sample(cbq_in_t req);
        cbq_out_t res;
        longint   smax;
        longint   x;
        longint   acc;
        longint   y;
        longint   d1;
        longint   d2;
        int       n;
        logic     clip;
        smax = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        x    = longint'($signed(req.sample_in));
        clip = 1'b0;
        if (req.clear_state)
        begin
            for (int s = 0; s < MAX_SECTIONS; s++)
            begin
                z1[s] = '0;
                z2[s] = '0;
            end
        end
        n = int'(sec_cnt);
        if (n < 1)
            n = 1;
        if (n > MAX_SECTIONS)
            n = MAX_SECTIONS;
        for (int s = 0; s < n; s++)
        begin
            acc = scaled_product(coefs.b0, x) + longint'(z1[s]);
            y   = round_half_up(acc, OUT_SHIFT);
            if (y > smax)
            begin
                y    = smax;
                clip = 1'b1;
            end
            else if (y < -smax - 1)
            begin
                y    = -smax - 1;
                clip = 1'b1;
            end
            d1 = scaled_product(coefs.b1, x) - scaled_product(coefs.a1, y) + longint'(z2[s]);
            d2 = scaled_product(coefs.b2, x) - scaled_product(coefs.a2, y);
            z1[s] = settle_delay(d1);
            z2[s] = settle_delay(d2);
            x = y;
        end
        res.sample_out = x[SAMPLE_WIDTH-1:0];
        res.clipped    = clip;
        return res;
    endfunction

    function automatic void apply_write(logic [2:0] idx, logic [COEF_WIDTH-1:0] data);
        case (reg_idx_t'(idx))
            REG_B0:       coefs.b0  = data;
            REG_B1:       coefs.b1  = data;
            REG_B2:       coefs.b2  = data;
            REG_A1:       coefs.a1  = data;
            REG_A2:       coefs.a2  = data;
            REG_SECTIONS: sec_cnt   = data[1:0];
            REG_FLUSH:    flush_lim = data[THR_W-1:0];
            default:      ;
        endcase
    endfunction

    function automatic void note_mismatch(string what, longint exp_v, longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d, %s: expected %0d, got %0d",
                     results_seen, what, exp_v, act_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs        = '0;
            sec_cnt      = 2'd2;
            flush_lim    = THR_W'(1);
            for (int s = 0; s < MAX_SECTIONS; s++)
            begin
                z1[s] = '0;
                z2[s] = '0;
            end
            expected_results.delete();
            mismatches   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);

            // retire first: a result never belongs to a request taken on the same edge
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected result, sample_out",
                                  0, longint'($signed(result_req.sample_out)));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_req.sample_out !== want.sample_out)
                        note_mismatch("sample_out", longint'($signed(want.sample_out)),
                                      longint'($signed(result_req.sample_out)));
                    if (result_req.clipped !== want.clipped)
                        note_mismatch("clipped", longint'(want.clipped),
                                      longint'(result_req.clipped));
                end
                results_seen++;
            end

            if (sample_valid && !sample_stall)
                expected_results.push_back(filter_sample(sample_req));

            pending = expected_results.size();
        end
    end

endmodule

/* tb/cascaded_biquad_filter_tb.sv */
`timescale 1ns / 1ps

module cascaded_biquad_filter_tb;

    import cbq_pkg::*;
    import cbq_tb_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX =
        SAMPLE_WIDTH'(2 ** (SAMPLE_WIDTH - 1) - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN =
        SAMPLE_WIDTH'(-(2 ** (SAMPLE_WIDTH - 1)));
    localparam logic [COEF_WIDTH-1:0]          COEF_ONE = 32'h1000_0000;  // 1.0 in Q3.28

    localparam int PHASES        = 29;
    localparam int PHASE_SAMPLES = 50;

    typedef enum int { COEF_WILD, COEF_STABLE, COEF_EXTREME } coef_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    cbq_in_t               sample_req;
    logic                  result_valid;
    logic                  result_stall;
    cbq_out_t              result_req;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [COEF_WIDTH-1:0] cfg_data;

    int mismatches;
    int pending;

    // When set, neither side inserts gaps or stalls: back-to-back stretches.
    bit busy_run;
    int stall_left;

    cascaded_biquad_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_req   (sample_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_req   (result_req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Watches all three channels, tracks the filter state and scores results.
    cascaded_biquad_filter_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_req   (sample_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_req   (result_req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop. The slowest legal run is roughly 1500 requests, each paying a sender
    // gap, the filter run and a receiver stall, about 1.5 ms in all.
    initial
    begin
        #10_000_000;
        $display("cascaded_biquad_filter_tb failed");
        $finish;
    end

    function automatic int pick_gap();
        return busy_run ? 0 : $urandom_range(0, 16);
    endfunction

    // Receiver: a fresh stall length is drawn for every result. The count is
    // kept on rising edges and turned into stall on the following falling edge.
    initial
    begin
        result_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                stall_left = pick_gap();
            else if (result_valid && stall_left != 0)
                stall_left--;
            @(negedge clk);
            result_stall <= (stall_left != 0);
        end
    end

    // One sample request. Entered and left on a falling edge; valid stays up
    // across back-to-back requests so it is never dropped and raised in one step.
    task automatic send_sample(cbq_in_t req);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_req   <= req;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    function automatic cbq_in_t pack_req(logic signed [SAMPLE_WIDTH-1:0] smp, logic clr);
        cbq_in_t req;
        req.sample_in   = smp;
        req.clear_state = clr;
        return req;
    endfunction

    // Hold off the sender until every outstanding result has been taken.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [COEF_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_coefs(logic [COEF_WIDTH-1:0] b0, logic [COEF_WIDTH-1:0] b1,
                               logic [COEF_WIDTH-1:0] b2, logic [COEF_WIDTH-1:0] a1,
                               logic [COEF_WIDTH-1:0] a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    function automatic logic [COEF_WIDTH-1:0] extreme_coef();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return COEF_ONE;
            4:       return 32'hFFFF_FFFF;
            default: return 32'hF000_0000;
        endcase
    endfunction

    // +/- half scale in Q3.28
    function automatic logic [COEF_WIDTH-1:0] half_coef();
        return COEF_WIDTH'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000);
    endfunction

    // Rewrites every register. Upper data bits of the narrow registers carry
    // random junk the block has to drop.
    task automatic program_filter(coef_style_t style);
        logic [COEF_WIDTH-1:0] junk;
        logic [THR_W-1:0]      thr;
        case (style)
            COEF_WILD:
                write_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            COEF_STABLE:
                // |a1| <= 0.5, |a2| <= 0.4: poles well inside the unit circle
                write_coefs(half_coef(), half_coef(), half_coef(), half_coef(),
                            COEF_WIDTH'(int'($urandom_range(0, 214748364)) - 107374182));
            default:
                write_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                            extreme_coef(), extreme_coef());
        endcase
        junk = $urandom;
        write_reg(REG_SECTIONS, {junk[COEF_WIDTH-1:2], 2'($urandom_range(0, 3))});
        case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = THR_W'(1);
            2:       thr = '1;
            3:       thr = THR_W'($urandom_range(0, 255));
            default: thr = THR_W'($urandom);
        endcase
        junk = $urandom;
        write_reg(REG_FLUSH, {junk[COEF_WIDTH-1:THR_W], thr});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Random sample: mostly scaled-down noise, with rails and rare state clears.
    function automatic cbq_in_t random_req(int shift);
        logic signed [SAMPLE_WIDTH-1:0] raw;
        logic                           clr;
        raw = SAMPLE_WIDTH'($urandom);
        clr = ($urandom_range(0, 24) == 0);
        case ($urandom_range(0, 19))
            0:       return pack_req(SMP_MAX, clr);
            1:       return pack_req(SMP_MIN, clr);
            2:       return pack_req(raw, clr);
            default: return pack_req(raw >>> shift, clr);
        endcase
    endfunction

    initial
    begin
        int shift;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_req   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        busy_run     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values: zero coefficients give a silent output, two sections.
        send_sample(pack_req(SMP_MAX, 1'b0));
        send_sample(pack_req(SMP_MIN, 1'b1));

        // Pass-through: b0 = 1.0, section count zero acts as one section,
        // zero flush threshold, and a write to the spare index must be ignored.
        wait_drained();
        write_coefs(COEF_ONE, '0, '0, '0, '0);
        write_reg(REG_SECTIONS, '0);
        write_reg(REG_FLUSH, '0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_sample(pack_req(SMP_MAX, 1'b0));
        send_sample(pack_req(SMP_MIN, 1'b0));
        send_sample(pack_req('0, 1'b0));
        send_sample(pack_req('1, 1'b0));
        send_sample(pack_req(SAMPLE_WIDTH'(1), 1'b0));

        // Rail coefficients, count above the maximum clamps to two sections,
        // largest flush threshold. Heavy clipping in both sections.
        wait_drained();
        write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_reg(REG_SECTIONS, 32'hFFFF_FFFF);
        write_reg(REG_FLUSH, 32'h0000_FFFF);
        cfg_valid <= 1'b0;
        send_sample(pack_req(SMP_MAX, 1'b0));
        send_sample(pack_req(SMP_MIN, 1'b0));
        send_sample(pack_req(SMP_MAX, 1'b0));
        send_sample(pack_req('0, 1'b1));
        send_sample(pack_req(SMP_MIN, 1'b0));
        send_sample(pack_req('1, 1'b0));

        // Drop to one section: the second section's delays must hold, then
        // come back into play when two sections are enabled again.
        wait_drained();
        write_reg(REG_SECTIONS, 32'd1);
        cfg_valid <= 1'b0;
        send_sample(pack_req(SMP_MAX, 1'b0));
        send_sample(pack_req(SAMPLE_WIDTH'(-12345), 1'b0));
        wait_drained();
        write_reg(REG_SECTIONS, 32'd2);
        cfg_valid <= 1'b0;
        send_sample(pack_req(SAMPLE_WIDTH'(4096), 1'b0));
        send_sample(pack_req(SMP_MIN, 1'b0));

        // Random phases, each with a fresh register set. Every fourth phase
        // runs with no gaps or stalls at all.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            busy_run = (p % 4 == 3);
            program_filter(coef_style_t'($urandom_range(0, 2)));
            shift = $urandom_range(0, 20);
            for (int i = 0; i < PHASE_SAMPLES; i++)
            begin
                send_sample(random_req(shift));
                // occasional full hold-off in the middle of a phase
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("cascaded_biquad_filter_tb passed");
        else
            $display("cascaded_biquad_filter_tb failed");
        $finish;
    end

endmodule
